// File: sv/cwc_pkg.sv
// Shared types and constants for the color window centroid tracker.
// No dependencies; imported by every module of the block.
package cwc_pkg;

    localparam int IMAGE_WIDTH  = 320;
    localparam int IMAGE_HEIGHT = 240;

    // Field widths
    localparam int HUE_W   = 8;
    localparam int SAT_W   = 8;
    localparam int VAL_W   = 8;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int CNT_W   = 17;
    localparam int SUM_W   = 25;
    localparam int RAD_W   = 9;
    localparam int LIM_W   = 9;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 9;

    // Window arithmetic widths
    localparam int DIFF_W = 11;             // signed col/row offset before range check
    localparam int OFFS_W = 10;             // signed offset once inside [-r, r-1]
    localparam int SQ_W   = 2 * RAD_W;      // squared offset / radius
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic [COL_W-1:0] CENTRE_X_RESET = COL_W'(160);
    localparam logic [ROW_W-1:0] CENTRE_Y_RESET = ROW_W'(120);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_A_W-1:0] {
        CFG_HUE_ABOVE  = 3'd0,
        CFG_HUE_BELOW  = 3'd1,
        CFG_SAT_MIN    = 3'd2,
        CFG_SAT_MAX    = 3'd3,
        CFG_VAL_MIN    = 3'd4,
        CFG_VAL_MAX    = 3'd5,
        CFG_WIN_RADIUS = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_accepted;
        logic last_retired;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: sv/cwc_div.sv
// Dual restoring divider: two dividends share one divisor, one quotient bit a cycle.
// Depends on cwc_pkg.
module cwc_div
    import cwc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend_a,
    input  logic [SUM_W-1:0] i_dividend_b,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quot_a,
    output logic [SUM_W-1:0] o_quot_b
);

    logic [SUM_W-1:0]     r_qa, n_qa, r_qb, n_qb;
    logic [CNT_W-1:0]     r_ra, n_ra, r_rb, n_rb;
    logic [CNT_W-1:0]     r_d;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;

    logic [CNT_W:0] trial_a, trial_b, diff_a, diff_b;
    logic           ge_a, ge_b;

    always_comb begin
        trial_a = {r_ra, r_qa[SUM_W-1]};
        trial_b = {r_rb, r_qb[SUM_W-1]};
        diff_a  = trial_a - {1'b0, r_d};
        diff_b  = trial_b - {1'b0, r_d};
        ge_a    = trial_a >= {1'b0, r_d};
        ge_b    = trial_b >= {1'b0, r_d};
        n_ra    = ge_a ? diff_a[CNT_W-1:0] : trial_a[CNT_W-1:0];
        n_rb    = ge_b ? diff_b[CNT_W-1:0] : trial_b[CNT_W-1:0];
        n_qa    = {r_qa[SUM_W-2:0], ge_a};
        n_qb    = {r_qb[SUM_W-2:0], ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qa <= i_dividend_a;
            r_qb <= i_dividend_b;
            r_ra <= '0;
            r_rb <= '0;
            r_d  <= i_divisor;
        end else if (r_busy) begin
            r_qa <= n_qa;
            r_qb <= n_qb;
            r_ra <= n_ra;
            r_rb <= n_rb;
        end
    end

    assign o_done   = r_done;
    assign o_quot_a = r_qa;
    assign o_quot_b = r_qb;

endmodule

// File: sv/cwc_dpath.sv
// Datapath: config registers, pixel classify/window pipeline, accumulators,
// centre register, divider and output register. Depends on cwc_pkg, cwc_div.
module cwc_dpath
    import cwc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_cfg_we,
    input  logic [CFG_A_W-1:0]     i_cfg_addr,
    input  logic [CFG_D_W-1:0]     i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_in_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic                   o_out_found
);

    // config
    logic [LIM_W-1:0]   r_hue_above, r_hue_below, r_sat_max, r_val_max;
    logic [SAT_W-1:0]   r_sat_min;
    logic [VAL_W-1:0]   r_val_min;
    logic [RAD_W-1:0]   r_rad;
    logic [SQ_W-1:0]    r_rad_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_above <= LIM_W'(320);
            r_hue_below <= LIM_W'(40);
            r_sat_min   <= SAT_W'(95);
            r_sat_max   <= LIM_W'(255);
            r_val_min   <= VAL_W'(95);
            r_val_max   <= LIM_W'(255);
            r_rad       <= RAD_W'(160);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_HUE_ABOVE:  r_hue_above <= i_cfg_wdata;
                CFG_HUE_BELOW:  r_hue_below <= i_cfg_wdata;
                CFG_SAT_MIN:    r_sat_min   <= i_cfg_wdata[SAT_W-1:0];
                CFG_SAT_MAX:    r_sat_max   <= i_cfg_wdata;
                CFG_VAL_MIN:    r_val_min   <= i_cfg_wdata[VAL_W-1:0];
                CFG_VAL_MAX:    r_val_max   <= i_cfg_wdata;
                CFG_WIN_RADIUS: r_rad       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad_sq <= r_rad * r_rad;
    end

    // input unpack
    logic [HUE_W-1:0] in_hue;
    logic [SAT_W-1:0] in_sat;
    logic [VAL_W-1:0] in_val;
    logic [COL_W-1:0] in_col;
    logic [ROW_W-1:0] in_row;
    logic             accept;

    assign in_hue = i_in_data[7:0];
    assign in_sat = i_in_data[15:8];
    assign in_val = i_in_data[23:16];
    assign in_col = i_in_data[32:24];
    assign in_row = i_in_data[40:33];
    assign accept = i_in_valid && i_cmd.in_ready;

    logic [COL_W-1:0] r_centre_x;
    logic [ROW_W-1:0] r_centre_y;

    // stage 1: classify, offsets and range check
    logic               hue_ok, colour_ok, in_frame, x_ok, y_ok;
    logic signed [DIFF_W-1:0] dx, dy, rad_s, neg_rad;

    always_comb begin
        hue_ok    = ({1'b0, in_hue} > r_hue_above) || ({1'b0, in_hue} < r_hue_below);
        colour_ok = hue_ok && (in_sat > r_sat_min) && ({1'b0, in_sat} < r_sat_max)
                    && (in_val > r_val_min) && ({1'b0, in_val} < r_val_max);
        in_frame  = (in_col < COL_W'(IMAGE_WIDTH)) && (in_row < ROW_W'(IMAGE_HEIGHT));
        dx        = $signed({2'b00, in_col}) - $signed({2'b00, r_centre_x});
        dy        = $signed({3'b000, in_row}) - $signed({3'b000, r_centre_y});
        rad_s     = $signed({2'b00, r_rad});
        neg_rad   = -rad_s;
        x_ok      = (dx >= neg_rad) && (dx < rad_s);
        y_ok      = (dy >= neg_rad) && (dy < rad_s);
    end

    logic                     r_s1_valid, r_s1_pass, r_s1_last;
    logic signed [OFFS_W-1:0] r_s1_dx, r_s1_dy;
    logic [COL_W-1:0]         r_s1_col, r_s2_col, r_s3_col;
    logic [ROW_W-1:0]         r_s1_row, r_s2_row, r_s3_row;
    logic                     r_s2_valid, r_s2_pass, r_s2_last;
    logic [SQ_W-1:0]          r_s2_dxsq, r_s2_dysq;
    logic                     r_s3_valid, r_s3_hit, r_s3_last;

    logic signed [2*OFFS_W-1:0] dx_prod, dy_prod;
    logic [SQ_W:0]              dist_sq;

    assign dx_prod = r_s1_dx * r_s1_dx;
    assign dy_prod = r_s1_dy * r_s1_dy;
    assign dist_sq = {1'b0, r_s2_dxsq} + {1'b0, r_s2_dysq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pass <= colour_ok && in_frame && x_ok && y_ok;
        r_s1_last <= i_in_last;
        r_s1_dx   <= dx[OFFS_W-1:0];
        r_s1_dy   <= dy[OFFS_W-1:0];
        r_s1_col  <= in_col;
        r_s1_row  <= in_row;

        r_s2_pass <= r_s1_pass;
        r_s2_last <= r_s1_last;
        r_s2_dxsq <= dx_prod[SQ_W-1:0];
        r_s2_dysq <= dy_prod[SQ_W-1:0];
        r_s2_col  <= r_s1_col;
        r_s2_row  <= r_s1_row;

        r_s3_hit  <= r_s2_pass && (dist_sq <= {1'b0, r_rad_sq});
        r_s3_last <= r_s2_last;
        r_s3_col  <= r_s2_col;
        r_s3_row  <= r_s2_row;
    end

    // accumulators, saturating
    logic [SUM_W-1:0] r_sum_cols, r_sum_rows;
    logic [CNT_W-1:0] r_hits, r_hits_hold;
    logic [SUM_W:0]   add_cols, add_rows;

    assign add_cols = {1'b0, r_sum_cols} + (SUM_W+1)'(r_s3_col);
    assign add_rows = {1'b0, r_sum_rows} + (SUM_W+1)'(r_s3_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_cols <= '0;
            r_sum_rows <= '0;
            r_hits     <= '0;
        end else if (i_cmd.div_start) begin
            r_sum_cols <= '0;
            r_sum_rows <= '0;
            r_hits     <= '0;
        end else if (r_s3_valid && r_s3_hit) begin
            r_sum_cols <= add_cols[SUM_W] ? SUM_MAX : add_cols[SUM_W-1:0];
            r_sum_rows <= add_rows[SUM_W] ? SUM_MAX : add_rows[SUM_W-1:0];
            if (r_hits != CNT_MAX) begin
                r_hits <= r_hits + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_hits_hold <= r_hits;
        end
    end

    // divider
    logic             div_done;
    logic [SUM_W-1:0] quot_cols, quot_rows;

    cwc_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_cmd.div_start),
        .i_dividend_a (r_sum_cols),
        .i_dividend_b (r_sum_rows),
        .i_divisor    (r_hits),
        .o_done       (div_done),
        .o_quot_a     (quot_cols),
        .o_quot_b     (quot_rows)
    );

    // centre and output register
    logic             hits_nz;
    logic [COL_W-1:0] n_centre_x;
    logic [ROW_W-1:0] n_centre_y;
    logic             r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic             r_out_found;

    assign hits_nz    = r_hits_hold != '0;
    assign n_centre_x = hits_nz ? quot_cols[COL_W-1:0] : r_centre_x;
    assign n_centre_y = hits_nz ? quot_rows[ROW_W-1:0] : r_centre_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x  <= CENTRE_X_RESET;
            r_centre_y  <= CENTRE_Y_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_centre_x  <= n_centre_x;
                r_centre_y  <= n_centre_y;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data  <= OUT_TDATA_W'({r_hits_hold, n_centre_y, n_centre_x});
            r_out_found <= hits_nz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_found = r_out_found;

    assign o_status.last_accepted = accept && i_in_last;
    assign o_status.last_retired  = r_s3_valid && r_s3_last;
    assign o_status.div_done      = div_done;
    assign o_status.out_free      = !r_out_valid || i_out_ready;

endmodule

// File: sv/cwc_ctrl.sv
// Frame controller: sequences accumulate, drain, divide and result load.
// Depends on cwc_pkg.
module cwc_ctrl
    import cwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_ACCUM: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.last_accepted) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // frame-end pixel reaches the accumulators
                if (i_status.last_retired) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

endmodule

// File: sv/color_window_centroid.sv
// Top level of the color window centroid tracker.
// Depends on cwc_pkg, cwc_ctrl, cwc_dpath (which holds cwc_div).
//
// Tracks one colored object in a raster stream of HSV pixels. Each pixel is
// tested for object color (hue above hue_above or below hue_below, sat and val
// strictly inside their bounds) and for lying inside a circular window of
// window_radius around the current centre; hits are summed. Pixels are taken
// one per clock through a three-stage classify/square/compare pipeline. The
// pixel with tlast closes the frame: s_axis_tready drops while the pipeline
// drains and stays low through the start state, a shared 25-step restoring
// divider (one quotient bit per cycle for both column and row sums) and the
// load of the result register; that load is held back for as long as the
// previous result has not yet been taken downstream. The result carries
// the new centre (unchanged if no hit) and the hit count; found is set when
// the count is nonzero. Config registers are written by index through the
// i_cfg port; write them only while no frame is in flight. Pixels outside
// 320x240 never count; accumulators saturate on overlong frames.
module color_window_centroid
    import cwc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_A_W-1:0]     i_cfg_addr,
    input  logic [CFG_D_W-1:0]     i_cfg_wdata,
    // pixel stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // hue[7:0] sat[15:8] val[23:16]
                                                  // col[32:24] row[40:33], rest 0
    input  logic                   s_axis_tlast,  // frame_end
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // centre_col[8:0] centre_row[16:9]
                                                  // pixel_count[33:17], rest 0
    output logic                   m_axis_tuser   // found
);

    t_cmd    cmd;
    t_status status;

    cwc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cwc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_found (m_axis_tuser)
    );

    // ready is a state decode only, so it never depends on s_axis_tvalid
    assign s_axis_tready = cmd.in_ready;

endmodule
